/* rtl/tbdq_pkg.sv */
// Shared constants, register codes and types for the tile box downsampler.
`timescale 1ns / 1ps
`default_nettype none

package tbdq_pkg;

    // Source tile geometry (power of two).
    localparam int TILE_SIDE  = 256;
    localparam int COORD_W    = $clog2(TILE_SIDE);
    localparam int LINE_DEPTH = TILE_SIDE / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int DEST_CALC_W = (COORD_W + 2 > 8) ? COORD_W + 2 : 8;

    // Pixel and accumulator widths.
    localparam int NUM_CH = 4;
    localparam int PIX_W  = 8;
    localparam int SUM_W  = 12;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_ROW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_COL    = 2'd3;

    localparam logic [2:0] CHANNELS_RGB   = 3'd3;
    localparam logic [2:0] CHANNELS_RGBA  = 3'd4;

    typedef struct packed {
        logic       scale_mode;
        logic [2:0] channel_count;
        logic [1:0] region_row;
        logic [1:0] region_col;
    } cfg_t;

    typedef logic [SUM_W-1:0] sum_t;
    typedef sum_t [NUM_CH-1:0] sum_vec_t;
    typedef logic [NUM_CH-1:0] [PIX_W-1:0] pix_vec_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } pos_t;

    // Line store read / write control.
    typedef struct packed {
        logic               rd_en;
        logic [LINE_AW-1:0] rd_addr;
        logic               wr_en;
        logic [LINE_AW-1:0] wr_addr;
    } line_ctrl_t;

endpackage

`default_nettype wire

/* rtl/tbdq_ifs.sv */
// Handshake channel interfaces: source pixels, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface tbdq_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;

    modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                    input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2, input chan3,
                    output ready);
endinterface

interface tbdq_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] dest_row;
    logic [7:0] dest_col;
    logic [7:0] avg0;
    logic [7:0] avg1;
    logic [7:0] avg2;
    logic [7:0] avg3;

    modport source (output valid, output dest_row, output dest_col, output avg0,
                    output avg1, output avg2, output avg3, input ready);
    modport sink   (input valid, input dest_row, input dest_col, input avg0,
                    input avg1, input avg2, input avg3, output ready);
endinterface

interface tbdq_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [2:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/tile_box_downsample_into_quadrant.sv */
// Top level of the 2x2 / 4x4 box-filter tile downsampler.
//
// Source pixels enter in raster order; a new pixel can be taken every cycle unless the input
// stalls. The pixel that completes a block and its line store read are registered together at
// its transaction edge; the add and round then feed the result register, loaded once free.
// Throughput is set by the single line store read-write pair (one column-sum read per pixel,
// one write per block column) and is one pixel per cycle; the input stalls only while a
// finished result is held by the sink and the staged pixel completes another block. The line
// store needs no clearing after reset. Configuration writes take effect on the next pixel; the
// user must make them between tiles while no pixel is in flight; the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module tile_box_downsample_into_quadrant
    import tbdq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tbdq_pix_if.sink    pix,
    tbdq_res_if.source  res,
    tbdq_cfg_if.sink    cfg
);

    cfg_t       cfg_q;
    pos_t       pos;
    line_ctrl_t line_ctrl;
    sum_vec_t   col_sum_rd;
    sum_vec_t   col_sum_wr;
    pix_vec_t   pix_chan;
    pix_vec_t   avg;
    logic       accept;

    assign pix_chan[0] = pix.chan0;
    assign pix_chan[1] = pix.chan1;
    assign pix_chan[2] = pix.chan2;
    assign pix_chan[3] = pix.chan3;
    assign accept      = pix.valid && pix.ready;

    tbdq_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    tbdq_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .scale_mode (cfg_q.scale_mode),
        .pos        (pos),
        .rd_en      (line_ctrl.rd_en),
        .rd_addr    (line_ctrl.rd_addr)
    );

    tbdq_line_store u_line_store (
        .clk     (clk),
        .ctrl    (line_ctrl),
        .wr_data (col_sum_wr),
        .rd_data (col_sum_rd)
    );

    tbdq_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_q),
        .pix_valid  (pix.valid),
        .pix_ready  (pix.ready),
        .pix_chan   (pix_chan),
        .pix_pos    (pos),
        .col_sum_rd (col_sum_rd),
        .wr_en      (line_ctrl.wr_en),
        .wr_addr    (line_ctrl.wr_addr),
        .col_sum_wr (col_sum_wr),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .dest_row   (res.dest_row),
        .dest_col   (res.dest_col),
        .avg        (avg)
    );

    assign res.avg0 = avg[0];
    assign res.avg1 = avg[1];
    assign res.avg2 = avg[2];
    assign res.avg3 = avg[3];

endmodule

`default_nettype wire

/* rtl/tbdq_cfg_regs.sv */
// Configuration register file written through the configuration channel.
`timescale 1ns / 1ps
`default_nettype none

module tbdq_cfg_regs
    import tbdq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_valid,
    output logic                       wr_ready,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always take a write transaction.
    assign wr_ready = 1'b1;

    // Decode the register index.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            unique case (wr_index)
                REG_SCALE_MODE:    cfg_next.scale_mode    = wr_data[0];
                REG_CHANNEL_COUNT: cfg_next.channel_count = wr_data;
                REG_REGION_ROW:    cfg_next.region_row    = wr_data[1:0];
                REG_REGION_COL:    cfg_next.region_col    = wr_data[1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_mode    <= 1'b0;
            cfg_reg.channel_count <= CHANNELS_RGBA;
            cfg_reg.region_row    <= 2'd0;
            cfg_reg.region_col    <= 2'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/tbdq_scan.sv */
// Source position counters and line store read issue for each accepted pixel.
`timescale 1ns / 1ps
`default_nettype none

module tbdq_scan
    import tbdq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic       scale_mode,
    output pos_t            pos,
    output logic            rd_en,
    output logic [LINE_AW-1:0] rd_addr
);

    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] row_next;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] col_next;

    // Advance in raster order, wrap at the tile end.
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (col_reg == COORD_W'(TILE_SIDE - 1))
            begin
                col_next = '0;
                if (row_reg == COORD_W'(TILE_SIDE - 1))
                    row_next = '0;
                else
                    row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign pos.row = row_reg;
    assign pos.col = col_reg;

    // Fetch the column sum of this pixel's block column.
    assign rd_en   = accept;
    assign rd_addr = scale_mode ? {1'b0, col_reg[COORD_W-1:2]} : col_reg[COORD_W-1:1];

endmodule

`default_nettype wire

/* rtl/tbdq_line_store.sv */
// Line store of per-block-column partial sums with registered read.
`timescale 1ns / 1ps
`default_nettype none

module tbdq_line_store
    import tbdq_pkg::*;
(
    input  wire logic       clk,
    input  wire line_ctrl_t ctrl,
    input  wire sum_vec_t   wr_data,
    output sum_vec_t        rd_data
);

    sum_vec_t mem [LINE_DEPTH];
    sum_vec_t rd_data_reg;

    // Write finished column sums.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
            mem[ctrl.wr_addr] <= wr_data;
    end

    // Read with registered data.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
            rd_data_reg <= mem[ctrl.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/tbdq_accum.sv */
// Pixel stage, block accumulation, rounding and result register.
`timescale 1ns / 1ps
`default_nettype none

module tbdq_accum
    import tbdq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    // source pixel side
    input  wire logic       pix_valid,
    output logic            pix_ready,
    input  wire pix_vec_t   pix_chan,
    input  wire pos_t       pix_pos,
    // line store side
    input  wire sum_vec_t   col_sum_rd,
    output logic            wr_en,
    output logic [LINE_AW-1:0] wr_addr,
    output sum_vec_t        col_sum_wr,
    // result side
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic [7:0]      dest_row,
    output logic [7:0]      dest_col,
    output pix_vec_t        avg
);

    logic      s1_valid_reg;
    pix_vec_t  s1_chan_reg;
    pos_t      s1_pos_reg;
    sum_vec_t  rp_reg;
    sum_vec_t  rp_next;

    logic      res_valid_reg;
    logic [7:0] dest_row_reg;
    logic [7:0] dest_col_reg;
    pix_vec_t  avg_reg;

    logic [1:0] phase_mask;
    logic       block_end;
    logic       last_row;
    logic       produce;
    logic       out_free;
    logic       s1_fire;
    logic       rgb;
    sum_vec_t   rp_sum;
    sum_vec_t   blk_sum;
    pix_vec_t   avg_val;
    logic [COORD_W-1:0]     row_blk;
    logic [COORD_W-1:0]     col_blk;
    logic [DEST_CALC_W-1:0] q_row;
    logic [DEST_CALC_W-1:0] q_col;
    logic [DEST_CALC_W-1:0] dest_row_calc;
    logic [DEST_CALC_W-1:0] dest_col_calc;

    // Block phase of the staged pixel.
    assign phase_mask = cfg.scale_mode ? 2'b11 : 2'b01;
    assign block_end  = (s1_pos_reg.col[1:0] & phase_mask) == phase_mask;
    assign last_row   = (s1_pos_reg.row[1:0] & phase_mask) == phase_mask;
    assign produce    = s1_valid_reg && block_end && last_row;
    assign rgb        = cfg.channel_count == CHANNELS_RGB;

    // Stall the stage only when a result waits on a full output register.
    assign out_free  = !res_valid_reg || res_ready;
    assign s1_fire   = s1_valid_reg && (!produce || out_free);
    assign pix_ready = !s1_valid_reg || s1_fire;

    // Hold the accepted pixel while the line store read completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pix_ready)
            s1_valid_reg <= pix_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pix_valid && pix_ready)
        begin
            s1_chan_reg <= pix_chan;
            s1_pos_reg  <= pix_pos;
        end
    end

    // Add the pixel to the row partial, then the stored column sum.
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (c == NUM_CH - 1 && rgb)
                rp_sum[c] = rp_reg[c];
            else
                rp_sum[c] = rp_reg[c] + SUM_W'(s1_chan_reg[c]);
            if ((s1_pos_reg.row[1:0] & phase_mask) != 2'b00)
                blk_sum[c] = col_sum_rd[c] + rp_sum[c];
            else
                blk_sum[c] = rp_sum[c];
        end
    end

    assign rp_next = block_end ? '0 : rp_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rp_reg <= '0;
        else if (s1_fire)
            rp_reg <= rp_next;
    end

    // Store the column sum for a block that is not yet complete.
    assign col_blk    = cfg.scale_mode ? (s1_pos_reg.col >> 2) : (s1_pos_reg.col >> 1);
    assign wr_en      = s1_fire && block_end && !last_row;
    assign wr_addr    = col_blk[LINE_AW-1:0];
    assign col_sum_wr = blk_sum;

    // Round, saturate and mask the averages.
    always_comb
    begin
        logic [SUM_W:0] rounded;
        logic [SUM_W:0] shifted;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (cfg.scale_mode)
            begin
                rounded = {1'b0, blk_sum[c]} + (SUM_W+1)'(8);
                shifted = rounded >> 4;
            end
            else
            begin
                rounded = {1'b0, blk_sum[c]} + (SUM_W+1)'(2);
                shifted = rounded >> 2;
            end
            if (c == NUM_CH - 1 && rgb)
                avg_val[c] = '0;
            else if (shifted > (SUM_W+1)'(255))
                avg_val[c] = 8'hFF;
            else
                avg_val[c] = shifted[7:0];
        end
    end

    // Place the block inside the chosen sub-region.
    assign row_blk = cfg.scale_mode ? (s1_pos_reg.row >> 2) : (s1_pos_reg.row >> 1);
    assign q_row   = cfg.scale_mode
                   ? (DEST_CALC_W'(cfg.region_row) << (COORD_W - 2))
                   : (DEST_CALC_W'(cfg.region_row[0]) << (COORD_W - 1));
    assign q_col   = cfg.scale_mode
                   ? (DEST_CALC_W'(cfg.region_col) << (COORD_W - 2))
                   : (DEST_CALC_W'(cfg.region_col[0]) << (COORD_W - 1));
    assign dest_row_calc = DEST_CALC_W'(row_blk) + q_row;
    assign dest_col_calc = DEST_CALC_W'(col_blk) + q_col;

    // Load the result register when it is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (out_free)
            res_valid_reg <= produce;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && produce)
        begin
            dest_row_reg <= dest_row_calc[7:0];
            dest_col_reg <= dest_col_calc[7:0];
            avg_reg      <= avg_val;
        end
    end

    assign res_valid = res_valid_reg;
    assign dest_row  = dest_row_reg;
    assign dest_col  = dest_col_reg;
    assign avg       = avg_reg;

endmodule

`default_nettype wire

/* rtl/tbdq_checker.sv */
// Port-level checker for the tile downsampler and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tbdq_checker
    import tbdq_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  pix_ready,
    input wire logic                  res_valid,
    input wire logic                  res_ready,
    input wire logic [7:0]            res_dest_row,
    input wire logic [7:0]            res_avg0,
    input wire logic [7:0]            res_avg3,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic rgb_reg;

    // Track whether three channels are in use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rgb_reg <= 1'b0;
        else if (cfg_valid && cfg_ready && cfg_index == REG_CHANNEL_COUNT)
            rgb_reg <= (cfg_data == CHANNELS_RGB);
    end

    // Hold a stalled result.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_dest_row) && $stable(res_avg0))
        else $error("result payload changed while stalled");

    // Accept pixels whenever the result side is empty.
    a_pix_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> pix_ready)
        else $error("pixel channel stalled with empty result register");

    // Drop the fourth channel of a fresh result in RGB mode.
    a_rgb_avg3: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !$past(res_valid && !res_ready) && $past(rgb_reg) |-> res_avg3 == 8'd0)
        else $error("fourth channel nonzero with three channels");

endmodule

bind tile_box_downsample_into_quadrant tbdq_checker u_tbdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_ready    (pix.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_dest_row (res.dest_row),
    .res_avg0     (res.avg0),
    .res_avg3     (res.avg3),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data)
);

`default_nettype wire

/* tb/sv/tb_tile_box_downsample_into_quadrant.sv */
// Testbench for the tile box downsampler: streamed pixels checked against a block-average tracker.
`timescale 1ns / 1ps

typedef logic [3:0][7:0] pixel_t;

typedef struct packed {
    logic [7:0]       row;
    logic [7:0]       col;
    logic [3:0][7:0]  avg;
} block_avg_t;

// Track the downsampler state and queue the block averages it owes.
class block_average_tracker;
    bit          scale_4x;
    logic [2:0]  channels;
    logic [1:0]  region_row;
    logic [1:0]  region_col;
    logic [11:0] column_sums [tbdq_pkg::LINE_DEPTH][4];
    logic [11:0] row_partial [4];
    int unsigned src_row;
    int unsigned src_col;
    int unsigned pixel_count;
    int          errors;
    block_avg_t  owed_avgs [$];

    function new();
        scale_4x    = 1'b0;
        channels    = tbdq_pkg::CHANNELS_RGBA;
        region_row  = 2'd0;
        region_col  = 2'd0;
        src_row     = 0;
        src_col     = 0;
        pixel_count = 0;
        errors      = 0;
        foreach (column_sums[i, c])
            column_sums[i][c] = '0;
        foreach (row_partial[c])
            row_partial[c] = '0;
    endfunction

    function int pending();
        return owed_avgs.size();
    endfunction

    function void note_config(input logic [1:0] idx, input logic [2:0] bits);
        case (idx)
            tbdq_pkg::REG_SCALE_MODE:    scale_4x   = bits[0];
            tbdq_pkg::REG_CHANNEL_COUNT: channels   = bits;
            tbdq_pkg::REG_REGION_ROW:    region_row = bits[1:0];
            tbdq_pkg::REG_REGION_COL:    region_col = bits[1:0];
            default: ;
        endcase
    endfunction

    // Accumulate one source pixel; queue an average when it closes a block.
    function void note_pixel(input pixel_t px);
        int unsigned lg, pmask, rnd, j, rphase, span, a;
        logic [11:0] sums [4];
        logic [7:0]  v;
        block_avg_t  owed;
        lg    = scale_4x ? 2 : 1;
        pmask = (1 << lg) - 1;
        rnd   = 1 << (2 * lg - 1);
        for (int c = 0; c < 4; c++)
        begin
            v = (c == 3 && channels == tbdq_pkg::CHANNELS_RGB) ? 8'd0 : px[c];
            row_partial[c] = row_partial[c] + 12'(v);
        end
        if ((src_col & pmask) == pmask)
        begin
            j      = src_col >> lg;
            rphase = src_row & pmask;
            for (int c = 0; c < 4; c++)
            begin
                sums[c] = ((rphase != 0) ? column_sums[j][c] : 12'd0) + row_partial[c];
                row_partial[c] = '0;
            end
            if (rphase == pmask)
            begin
                span     = tbdq_pkg::TILE_SIDE >> lg;
                owed.row = 8'((src_row >> lg) + (scale_4x ? region_row : region_row[0]) * span);
                owed.col = 8'(j + (scale_4x ? region_col : region_col[0]) * span);
                for (int c = 0; c < 4; c++)
                begin
                    a = (int'(sums[c]) + rnd) >> (2 * lg);
                    if (a > 255)
                        a = 255;
                    if (c == 3 && channels == tbdq_pkg::CHANNELS_RGB)
                        a = 0;
                    owed.avg[c] = 8'(a);
                end
                owed_avgs.push_back(owed);
            end
            else
            begin
                for (int c = 0; c < 4; c++)
                    column_sums[j][c] = sums[c];
            end
        end
        pixel_count++;
        src_col++;
        if (src_col >= tbdq_pkg::TILE_SIDE)
        begin
            src_col = 0;
            src_row++;
            if (src_row >= tbdq_pkg::TILE_SIDE)
                src_row = 0;
        end
    endfunction

    task report(input string what);
        $display("MISMATCH: %s", what);
        errors++;
    endtask

    // Compare one delivered average against the oldest owed one.
    task check_average(input block_avg_t got);
        block_avg_t want;
        if (owed_avgs.size() == 0)
        begin
            report($sformatf("result (%0d,%0d) with nothing outstanding", got.row, got.col));
            return;
        end
        want = owed_avgs.pop_front();
        if (got.row !== want.row)
            report($sformatf("dest_row got %0d, want %0d", got.row, want.row));
        if (got.col !== want.col)
            report($sformatf("dest_col got %0d, want %0d", got.col, want.col));
        for (int c = 0; c < 4; c++)
        begin
            if (got.avg[c] !== want.avg[c])
                report($sformatf("avg%0d at (%0d,%0d) got %0d, want %0d",
                                 c, want.row, want.col, got.avg[c], want.avg[c]));
        end
    endtask
endclass

module tb_tile_box_downsample_into_quadrant;
    import tbdq_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 6;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DIRECTED_COUNT  = 24;
    localparam int FIRST_BUDGET    = 320;
    localparam int LAST_BUDGET     = 574;

    localparam int STYLE_MIXED = 0;
    localparam int STYLE_WHITE = 1;
    localparam int STYLE_BLACK = 2;

    logic clk;
    logic rst_n;

    tbdq_pix_if pix_ch ();
    tbdq_res_if res_ch ();
    tbdq_cfg_if cfg_ch ();

    tile_box_downsample_into_quadrant dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    block_average_tracker tracker;
    block_avg_t           seen_avg;
    int unsigned          cycle_count = 0;
    bit                   sender_calm = 1'b0;
    bit                   sink_calm   = 1'b0;
    int                   content_style = STYLE_MIXED;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** tile_box_downsample_into_quadrant: FAILED **");
            $finish;
        end
    end

    // Check each result transaction; values are stable at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen_avg.row    = res_ch.dest_row;
            seen_avg.col    = res_ch.dest_col;
            seen_avg.avg[0] = res_ch.avg0;
            seen_avg.avg[1] = res_ch.avg1;
            seen_avg.avg[2] = res_ch.avg2;
            seen_avg.avg[3] = res_ch.avg3;
            tracker.check_average(seen_avg);
        end
    end

    // Stall the result channel a random number of cycles before each transaction.
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                sink_calm = !sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(negedge clk);
            while (!res_ch.valid)
                @(negedge clk);
            @(posedge clk);
        end
    end

    function automatic pixel_t directed_pixel(input int k);
        pixel_t p;
        if (k == 0)
            p = '0;
        else if (k == 1)
            p = '1;
        else if (k == 2)
            p = {4{8'h55}};
        else if (k == 3)
            p = {4{8'hAA}};
        else if (k < 12)
            p = {4{8'(1 << (k - 4))}};
        else if (k < 20)
            p = {4{~8'(1 << (k - 12))}};
        else
        begin
            for (int c = 0; c < 4; c++)
                p[c] = (((k ^ c) & 1) != 0) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        for (int c = 0; c < 4; c++)
        begin
            if (content_style == STYLE_WHITE)
                p[c] = 8'hFF;
            else if (content_style == STYLE_BLACK)
                p[c] = 8'h00;
            else
            begin
                case ($urandom_range(0, 7))
                    0:       p[c] = 8'h00;
                    1:       p[c] = 8'hFF;
                    default: p[c] = 8'($urandom);
                endcase
            end
        end
        return p;
    endfunction

    // Hold a pixel on the channel until its transaction; valid stays high afterwards.
    task automatic send_pixel(input pixel_t p, input int gap);
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.chan0 <= p[0];
        pix_ch.chan1 <= p[1];
        pix_ch.chan2 <= p[2];
        pix_ch.chan3 <= p[3];
        @(negedge clk);
        while (!pix_ch.ready)
            @(negedge clk);
        tracker.note_pixel(p);
        @(posedge clk);
    endtask

    task automatic stream_pixels(input int count, input bit no_gaps);
        for (int k = 0; k < count; k++)
        begin
            if (!no_gaps && $urandom_range(0, 29) == 0)
                sender_calm = !sender_calm;
            send_pixel(random_pixel(), (no_gaps || sender_calm) ? 0 : $urandom_range(0, 11));
        end
    endtask

    // Write one register; valid stays high so writes can go back to back.
    task automatic write_reg(input logic [1:0] idx, input logic [2:0] bits);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= bits;
        @(negedge clk);
        while (!cfg_ch.ready)
            @(negedge clk);
        tracker.note_config(idx, bits);
        @(posedge clk);
    endtask

    // Drop valid, wait for every owed average, then let the pipeline empty.
    task automatic settle();
        pix_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pick new settings; keep 2x until the whole line store has been written once.
    task automatic reconfigure();
        if (tracker.pixel_count >= TILE_SIDE &&
            (tracker.src_col == 0 ? $urandom_range(0, 1) == 0 : $urandom_range(0, 9) == 0))
            write_reg(REG_SCALE_MODE, 3'($urandom));
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_CHANNEL_COUNT, ($urandom_range(0, 1) == 0) ? CHANNELS_RGB : 3'($urandom));
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_REGION_ROW, 3'($urandom));
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_REGION_COL, 3'($urandom));
        cfg_ch.valid <= 1'b0;
        if ($urandom_range(0, 3) == 0)
            content_style = $urandom_range(STYLE_MIXED, STYLE_BLACK);
    endtask

    // Alternate idle reconfiguration with pixel runs, often up to a row end.
    task automatic run_segments(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            settle();
            reconfigure();
            len = ($urandom_range(0, 2) == 0) ? TILE_SIDE - int'(tracker.src_col)
                                              : $urandom_range(1, 160);
            if (len > budget - sent)
                len = budget - sent;
            stream_pixels(len, 1'b0);
            sent += len;
        end
    endtask

    initial
    begin
        tracker = new();
        clk = 1'b0;
        rst_n = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.chan0 = '0;
        pix_ch.chan1 = '0;
        pix_ch.chan2 = '0;
        pix_ch.chan3 = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Touch every register; region indexes above 1 exercise the 2x wrap.
        write_reg(REG_SCALE_MODE, 3'b110);
        write_reg(REG_CHANNEL_COUNT, CHANNELS_RGB);
        write_reg(REG_REGION_ROW, 3'b111);
        write_reg(REG_REGION_COL, 3'b010);
        cfg_ch.valid <= 1'b0;

        // Extreme and walking-bit pixels open the first row.
        for (int k = 0; k < DIRECTED_COUNT; k++)
            send_pixel(directed_pixel(k), $urandom_range(0, 11));
        stream_pixels(TILE_SIDE - DIRECTED_COUNT, 1'b0);
        run_segments(FIRST_BUDGET);

        // Switch to 4x mid-tile; every column sum has been written by now.
        settle();
        write_reg(REG_SCALE_MODE, 3'b001);
        write_reg(REG_CHANNEL_COUNT, CHANNELS_RGBA);
        write_reg(REG_REGION_ROW, 3'b011);
        write_reg(REG_REGION_COL, 3'b101);
        cfg_ch.valid <= 1'b0;

        // Finish with more reconfiguration and idling.
        run_segments(LAST_BUDGET);
        settle();

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("** tile_box_downsample_into_quadrant: PASSED **");
        else
            $display("** tile_box_downsample_into_quadrant: FAILED **");
        $finish;
    end
endmodule
